/* rtl/hsfc_pkg.sv */
// Shared constants and types for the half/single float converter.
package hsfc_pkg;

    // Conversion selector
    typedef enum logic {
        KIND_HALF_TO_SINGLE = 1'b0,
        KIND_SINGLE_TO_HALF = 1'b1
    } t_kind;

    // Field layout
    localparam int unsigned HALF_MANT_W   = 10;
    localparam int unsigned HALF_EXP_W    = 5;
    localparam int unsigned SINGLE_MANT_W = 23;
    localparam int unsigned SINGLE_EXP_W  = 8;

    // Single exponent bias minus half exponent bias
    localparam logic [SINGLE_EXP_W-1:0] REBIAS       = 8'd112;
    // Smallest single exponent field that still takes the half subnormal path (ten below rebias)
    localparam logic [SINGLE_EXP_W-1:0] FLUSH_EXP    = 8'd102;
    // Single exponent field at which the half result overflows
    localparam logic [SINGLE_EXP_W-1:0] OVF_EXP      = 8'd143;
    // Right-shift base for subnormal half results (fourteen plus rebias)
    localparam logic [SINGLE_EXP_W-1:0] SUB_SHIFT    = 8'd126;

    localparam logic [15:0] HALF_INF   = 16'h7c00;
    localparam logic [31:0] SINGLE_INF = 32'h7f800000;
    localparam logic [23:0] ROUND_HALF = 24'h001000;

    localparam logic [HALF_EXP_W-1:0]   HALF_EXP_MAX   = '1;

endpackage

/* rtl/half_single_float_converter.sv */
// Half/single float converter: input register, conversion logic, result register.
// An accepted item moves from the input register into the result register once that register is free.
// Throughput: one item per cycle unless stalled; one more item is taken while a result waits.
// The conversion is a single pass of combinational logic between the two registers.
// Reset (synchronous, active low) clears the valid flags only; payload is not reset.
// No state carries between items.
module half_single_float_converter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  hsfc_pkg::t_kind      i_kind,
    input  logic [31:0]          i_operand_bits,
    // Result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [31:0]          o_converted_bits
);

    import hsfc_pkg::*;

    // Pipeline registers
    logic        r_in_valid;
    t_kind       r_kind;
    logic [31:0] r_bits;
    logic        r_out_valid;
    logic [31:0] r_converted;
    logic [31:0] n_converted;

    logic out_adv;
    logic in_adv;

    // Stage advance control
    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign o_stall = !in_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_adv) begin
            r_in_valid <= i_valid;
        end
        if (in_adv && i_valid) begin
            r_kind <= i_kind;
            r_bits <= i_operand_bits;
        end
    end

    // Half to single
    logic [HALF_MANT_W-1:0]  h_mant;
    logic [HALF_EXP_W-1:0]   h_exp;
    logic [3:0]              h_lz;
    logic [3:0]              h_shift;
    logic [HALF_MANT_W:0]    h_norm;
    logic [31:0]             h2s;

    always_comb begin
        h_mant = r_bits[HALF_MANT_W-1:0];
        h_exp  = r_bits[14:10];
        // leading zeros of the 10-bit mantissa; highest set bit wins
        h_lz = 4'd0;
        for (int i = 0; i < HALF_MANT_W; i++) begin
            if (h_mant[i]) begin
                h_lz = 4'(HALF_MANT_W - 1 - i);
            end
        end
        h_shift = h_lz + 4'd1;
        h_norm  = {1'b0, h_mant} << h_shift;
        if (h_exp == '0) begin
            if (h_mant == '0) begin
                h2s = {r_bits[15], 31'd0};
            end else begin
                h2s = {r_bits[15], REBIAS + 8'd1 - {4'd0, h_shift},
                       h_norm[HALF_MANT_W-1:0], 13'd0};
            end
        end else if (h_exp == HALF_EXP_MAX) begin
            h2s = {r_bits[15], 31'd0} | SINGLE_INF | {9'd0, h_mant, 13'd0};
        end else begin
            h2s = {r_bits[15], REBIAS + {3'd0, h_exp}, h_mant, 13'd0};
        end
    end

    // Single to half
    logic [SINGLE_EXP_W-1:0] s_exp;
    logic [23:0]             s_full;
    logic [7:0]              s_shift_w;
    logic [23:0]             s_sub;
    logic [23:0]             s_round;
    logic [7:0]              s_exp_h_w;
    logic [14:0]             s_norm;
    logic [15:0]             s2h;

    always_comb begin
        s_exp     = r_bits[30:23];
        s_full    = {1'b1, r_bits[SINGLE_MANT_W-1:0]};
        s_shift_w = SUB_SHIFT - s_exp;
        s_sub     = s_full >> s_shift_w[4:0];
        s_round   = {1'b0, r_bits[SINGLE_MANT_W-1:0]} + ROUND_HALF;
        s_exp_h_w = s_exp - REBIAS;
        // rounding carry adds into the exponent
        s_norm    = {s_exp_h_w[4:0], 10'd0} + {4'd0, s_round[23:13]};
        if (s_exp <= REBIAS) begin
            if (s_exp < FLUSH_EXP) begin
                s2h = {r_bits[31], 15'd0};
            end else begin
                s2h = {r_bits[31], 5'd0, s_sub[HALF_MANT_W-1:0]};
            end
        end else if (s_exp >= OVF_EXP) begin
            s2h = {r_bits[31], 15'd0} | HALF_INF;
        end else begin
            s2h = {r_bits[31], s_norm};
        end
    end

    // Result select
    always_comb begin
        case (r_kind)
            KIND_HALF_TO_SINGLE: n_converted = h2s;
            KIND_SINGLE_TO_HALF: n_converted = {16'd0, s2h};
            default:             n_converted = h2s;
        endcase
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (out_adv && r_in_valid) begin
            r_converted <= n_converted;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_converted_bits = r_converted;

    // Checks
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked item");

    a_item_moves_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_stall) |=> o_valid)
        else $error("item lost between stages");

    a_result_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_in_valid))
        else $error("result appeared without an item");

    a_half_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_adv && r_kind == KIND_SINGLE_TO_HALF)
        |=> (o_converted_bits[31:16] == 16'd0))
        else $error("half result has upper bits set");

endmodule

/* tb/conversion_checker.sv */
// Checker for the half/single float converter: predicts each conversion and compares results.
module conversion_checker
    import hsfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel, observed
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_kind       i_kind,
    input  logic [31:0] i_operand_bits,
    // Result channel, observed
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_converted_bits,
    // Status towards the testbench top
    output int          o_pending,
    output int          o_fail_count
);

    // Expected results in transfer order, kept in a ring
    logic [31:0] expected_bits [256];
    logic [7:0]  wr_ptr = '0;
    logic [7:0]  rd_ptr = '0;
    int          fill = 0;
    int          fails = 0;

    // Half to single is exact: subnormals are normalised, inf/NaN keep their payload
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [10:0] frac;
        logic [7:0]  ex;
        int          lz;
        frac = {1'b0, h[9:0]};
        if (h[14:10] == '0) begin
            if (h[9:0] == '0)
                return {h[15], 31'd0};
            lz = 0;
            while (!frac[10]) begin
                frac = frac << 1;
                lz++;
            end
            ex = 8'(113 - lz);
            return {h[15], ex, frac[9:0], 13'd0};
        end
        if (h[14:10] == HALF_EXP_MAX)
            return {h[15], 8'hff, h[9:0], 13'd0};
        ex = {3'd0, h[14:10]} + REBIAS;
        return {h[15], ex, h[9:0], 13'd0};
    endfunction

    // Single to half: flush, truncated subnormal, overflow to inf, round half up
    function automatic logic [31:0] narrow_single(input logic [31:0] f);
        int          ue;
        logic [31:0] sig;
        logic [31:0] sgn;
        logic [31:0] r;
        ue  = int'(f[30:23]) - int'(REBIAS);
        sig = {8'd0, 1'b1, f[22:0]};
        sgn = {16'd0, f[31], 15'd0};
        if (ue <= 0) begin
            if (ue < -10)
                return sgn;
            return sgn | (sig >> (14 - ue));
        end
        if (ue >= 31)
            return sgn | {16'd0, HALF_INF};
        // rounding carry is added, so it may run into the exponent
        r = sgn | ((32'(ue) << 10) + ((32'(f[22:0]) + 32'(ROUND_HALF)) >> 13));
        return r & 32'h0000_ffff;
    endfunction

    function automatic logic [31:0] convert_operand(input t_kind k, input logic [31:0] b);
        if (k == KIND_HALF_TO_SINGLE)
            return widen_half(b[15:0]);
        return narrow_single(b);
    endfunction

    // Record each input transfer, match each result transfer against the oldest
    always @(posedge i_clk) begin : watch
        logic [31:0] want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_bits[wr_ptr] = convert_operand(i_kind, i_operand_bits);
                wr_ptr = wr_ptr + 8'd1;
                fill++;
            end
            if (i_out_valid && !i_out_stall) begin
                if (fill == 0) begin
                    $error("converted_bits: unexpected result, expected none, actual %h",
                           i_converted_bits);
                    fails++;
                end else begin
                    want   = expected_bits[rd_ptr];
                    rd_ptr = rd_ptr + 8'd1;
                    fill--;
                    if (want !== i_converted_bits) begin
                        $error("converted_bits: expected %h, actual %h",
                               want, i_converted_bits);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= fill;
        o_fail_count <= fails;
    end

endmodule

/* tb/tb.sv */
// Testbench top for the half/single float converter: stimulus, idling phases and verdict.
module tb;
    import hsfc_pkg::*;

    localparam int HOLD_LEN       = 48;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PHASE = 100;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_kind       i_kind = KIND_HALF_TO_SINGLE;
    logic [31:0] i_operand_bits = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_converted_bits;

    int          pending;
    int          fail_count;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    logic        hold_kick = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    half_single_float_converter u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_kind           (i_kind),
        .i_operand_bits   (i_operand_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_converted_bits (o_converted_bits)
    );

    conversion_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_kind           (i_kind),
        .i_operand_bits   (i_operand_bits),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_converted_bits (o_converted_bits),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Result side: a long hold-off on request, otherwise random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_LEN;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one item, with random idle cycles first; returns after its transfer
    task automatic send_item(input t_kind k, input logic [31:0] b);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= k;
        i_operand_bits <= b;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Random operand, biased towards the exponent ranges where behaviour changes
    function automatic logic [31:0] random_operand(input t_kind k);
        logic [31:0] b;
        b = $urandom;
        if (k == KIND_SINGLE_TO_HALF) begin
            if ($urandom_range(0, 9) < 7)
                b[30:23] = 8'($urandom_range(98, 146));
            if ($urandom_range(0, 7) == 0)
                b[22:13] = '1;
            if ($urandom_range(0, 3) == 0)
                b[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0fff;
        end else begin
            case ($urandom_range(0, 3))
                0: b[14:10] = '0;
                1: b[14:10] = '1;
                default: ;
            endcase
        end
        return b;
    endfunction

    task automatic random_phase(input int tx_pct, input int rx_pct);
        t_kind k;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            k = t_kind'($urandom_range(0, 1));
            send_item(k, random_operand(k));
        end
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: half to single, zeros, subnormal ends, normal ends, inf, NaN
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_0000);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_8000);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_0001);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_83ff);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_0200);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_0400);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_7bff);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_fc00);
        send_item(KIND_HALF_TO_SINGLE, 32'h0000_7e01);
        // upper operand bits must be ignored
        send_item(KIND_HALF_TO_SINGLE, 32'hffff_3c00);
        send_item(KIND_HALF_TO_SINGLE, 32'hffff_ffff);
        // Directed: single to half, flush, subnormal, normal, rounding, overflow
        send_item(KIND_SINGLE_TO_HALF, 32'h0000_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'h8000_0001);
        send_item(KIND_SINGLE_TO_HALF, 32'h32ff_ffff);
        send_item(KIND_SINGLE_TO_HALF, 32'h3300_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'hb87f_ffff);
        send_item(KIND_SINGLE_TO_HALF, 32'h3880_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'h3f80_1000);
        send_item(KIND_SINGLE_TO_HALF, 32'h3f80_0fff);
        send_item(KIND_SINGLE_TO_HALF, 32'h477f_e000);
        // rounding carry out of the top exponent gives infinity
        send_item(KIND_SINGLE_TO_HALF, 32'hc77f_f000);
        send_item(KIND_SINGLE_TO_HALF, 32'h4780_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'hff80_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'h7fc0_0000);
        send_item(KIND_SINGLE_TO_HALF, 32'h7fff_ffff);
        drain();

        // Back-pressure: result side holds off while items keep coming
        hold_kick <= ~hold_kick;
        for (int n = 0; n < 30; n++)
            send_item(KIND_SINGLE_TO_HALF, random_operand(KIND_SINGLE_TO_HALF));
        drain();

        random_phase(0, 0);
        random_phase(68, 0);
        random_phase(0, 68);
        random_phase(21, 21);

        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
rtl/hsfc_pkg.sv
rtl/half_single_float_converter.sv
tb/conversion_checker.sv
tb/tb.sv
